// ----- rtl/apw_pkg.sv -----
// shared types and constants for the average pooling window block
package apw_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;

    // line store geometry
    localparam int unsigned MAX_CHANNELS = 64;
    localparam int unsigned MAX_IN_WIDTH = 128;
    localparam int unsigned MAX_WINDOW   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_W    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_H    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_W    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_H    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } t_state;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [6:0]  channels;
        logic [7:0]  out_w;
        logic [10:0] out_h;
        logic [2:0]  win_w;
        logic [2:0]  win_h;
        logic [2:0]  stride;
    } t_cfg;

    // position of a completed window
    typedef struct packed {
        logic        hit;
        logic [9:0]  oi;
        logic [6:0]  oj;
        logic [5:0]  ch;
        logic        last;
        logic [11:0] dr;
        logic [8:0]  dc;
    } t_win;

endpackage

// ----- rtl/average_pooling_window.sv -----
// top level of the streaming 2-d average pooling block
// an item that closes no window is written to the store; a window result is valid
//   after the window reads, the divide and ST_OUT, in that order
// throughput: one item per cycle without a window while no result waits, else
//   input stalls on the single store read port, 8-step divider and result handoff
// reset: synchronous active low; counters, configuration and state to defaults, store kept
module average_pooling_window
    import apw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_pixel,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_average,
    output logic [9:0]            o_out_row,
    output logic [6:0]            o_out_col,
    output logic [5:0]            o_out_channel,
    output logic                  o_frame_last
);
    localparam int unsigned ROW_SLOT = MAX_IN_WIDTH * MAX_CHANNELS;
    localparam int unsigned DEPTH    = MAX_WINDOW * ROW_SLOT;
    localparam int unsigned AW       = $clog2(DEPTH);
    localparam int unsigned SW       = $clog2(ROW_SLOT);
    localparam int unsigned MW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    t_cfg        cfg;
    logic        restart;
    logic [11:0] row;
    logic [8:0]  col;
    logic [5:0]  ch;
    t_win        win;
    logic        accept;

    t_state r_state, n_state;
    t_win   r_win;
    logic [2:0]  r_t, r_z;       // read cursor in the window
    logic        r_rd_vld;      // read data in flight
    logic [11:0] r_sum;
    logic [4:0]  area;
    logic [3:0]  r_dstep;
    logic [11:0] r_rem;
    logic [7:0]  r_quo;
    logic        r_ovld;
    logic [7:0]  r_avg;
    logic        rd_go, rd_done;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  rdata;
    logic [11:0] rrow;
    logic [8:0]  rcol;

    apw_cfg u_cfg (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_cfg(cfg), .o_restart(restart)
    );

    apw_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cfg(cfg), .i_restart(restart), .i_step(accept),
        .o_row(row), .o_col(col), .o_ch(ch), .o_win(win)
    );

    // address: row slot, then col*channels + ch, wrapped to the store
    function automatic logic [AW-1:0] addr_of(input logic [11:0] rr,
                                              input logic [8:0] cc,
                                              input logic [5:0] hh,
                                              input logic [6:0] nch);
        logic [MW-1:0] slot;
        logic [SW:0]   off;
        slot = MW'(rr % 12'(MAX_WINDOW));
        off  = (SW+1)'((SW+1)'(cc * nch) + (SW+1)'(hh));
        return AW'(AW'(slot) * AW'(ROW_SLOT) + AW'(off));
    endfunction

    assign waddr = addr_of(row, col, ch, cfg.channels);
    assign rrow  = r_win.dr + 12'(r_t);
    assign rcol  = r_win.dc + 9'(r_z);
    assign raddr = addr_of(rrow, rcol, r_win.ch, cfg.channels);

    // input accepted only when idle; stall while a window is in flight or a result waits
    assign o_stall = (r_state != ST_IDLE) || r_ovld;
    assign accept  = i_valid && !o_stall;

    // byte is written before reads start, so the window sees it
    apw_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .i_clk, .i_we(accept), .i_waddr(waddr), .i_wdata(i_pixel),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign area    = 5'(cfg.win_w * cfg.win_h);
    assign rd_go   = (r_state == ST_READ);
    assign rd_done = rd_go && ({1'b0, r_t} == 4'(cfg.win_h - 3'd1))
                     && ({1'b0, r_z} == 4'(cfg.win_w - 3'd1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept && win.hit) n_state = ST_READ;
            ST_READ: if (rd_done) n_state = ST_DIV;
            ST_DIV:  if (!r_rd_vld && r_dstep == 4'd8) n_state = ST_OUT;
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_go;
            if (r_state == ST_OUT) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && !i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // read cursor, accumulate, restoring divide one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && accept && win.hit) begin
            r_win <= win;
            r_t <= '0;
            r_z <= '0;
            r_sum <= '0;
            r_dstep <= '0;
        end
        if (rd_go && !rd_done) begin
            if ({1'b0, r_z} == 4'(cfg.win_w - 3'd1)) begin
                r_z <= '0;
                r_t <= r_t + 3'd1;
            end else begin
                r_z <= r_z + 3'd1;
            end
        end
        if (r_rd_vld) begin
            r_sum <= r_sum + 12'(rdata);
        end
        if (r_state == ST_DIV) begin
            if (r_rd_vld) begin
                r_rem <= '0;
                r_quo <= '0;
            end else if (r_dstep == 4'd0) begin
                r_rem <= r_sum;
                r_dstep <= 4'd1;
            end else if (r_dstep != 4'd8) begin
                r_dstep <= r_dstep + 4'd1;
            end
            if (!r_rd_vld && r_dstep != 4'd0) begin
                // quotient bit for weight 2^(8-dstep)
                if (r_rem >= (12'(area) << (4'd8 - r_dstep))) begin
                    r_rem <= r_rem - (12'(area) << (4'd8 - r_dstep));
                    r_quo <= r_quo | (8'd1 << (4'd8 - r_dstep));
                end
            end
        end
        if (r_state == ST_OUT) begin
            // register the quotient, rechecking the bit of weight one
            r_avg <= (r_rem >= 12'(area)) ? (r_quo | 8'd1) : r_quo;
        end
    end

    assign o_valid       = r_ovld;
    assign o_average     = r_avg;
    assign o_out_row     = r_win.oi;
    assign o_out_col     = r_win.oj;
    assign o_out_channel = r_win.ch;
    assign o_frame_last  = r_win.last;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !accept) else $error("accept while busy");
    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> $past(r_state == ST_OUT)) else $error("result without divide");
    a_read_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_go |-> (r_t < cfg.win_h) && (r_z < cfg.win_w)) else $error("read outside window");
endmodule

// ----- rtl/apw_ram.sv -----
// generic single port write, single port registered read ram
module apw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/apw_cfg.sv -----
// configuration registers with range saturation
module apw_cfg
    import apw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic                  o_restart
);
    localparam int unsigned CMAX = (MAX_CHANNELS < 64) ? MAX_CHANNELS : 64;
    localparam int unsigned WMAX = (MAX_WINDOW < 4) ? MAX_WINDOW : 4;

    t_cfg r_cfg, n_cfg;
    logic n_restart;

    function automatic logic [CFG_DATA_W-1:0] sat(input logic [CFG_DATA_W-1:0] v,
                                                  input logic [CFG_DATA_W-1:0] hi);
        if (v == '0) return CFG_DATA_W'(1);
        if (v > hi) return hi;
        return v;
    endfunction

    always_comb begin
        n_cfg     = r_cfg;
        n_restart = 1'b0;
        if (i_cfg_we) begin
            n_restart = 1'b1;
            unique case (i_cfg_index)
                REG_CHANNELS: n_cfg.channels = 7'(sat(i_cfg_data, CFG_DATA_W'(CMAX)));
                REG_OUT_W:    n_cfg.out_w    = 8'(sat(i_cfg_data, CFG_DATA_W'(128)));
                REG_OUT_H:    n_cfg.out_h    = 11'(sat(i_cfg_data, CFG_DATA_W'(1024)));
                REG_WIN_W:    n_cfg.win_w    = 3'(sat(i_cfg_data, CFG_DATA_W'(WMAX)));
                REG_WIN_H:    n_cfg.win_h    = 3'(sat(i_cfg_data, CFG_DATA_W'(WMAX)));
                REG_STRIDE:   n_cfg.stride   = 3'(sat(i_cfg_data, CFG_DATA_W'(4)));
                default:      n_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{channels: 7'd1, out_w: 8'd1, out_h: 11'd1,
                       win_w: 3'd1, win_h: 3'd1, stride: 3'd1};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // counters clear at the same edge that takes the write
    assign o_restart = n_restart;
    assign o_cfg     = r_cfg;
endmodule

// ----- rtl/apw_ctrl.sv -----
// input position counters and window completion detect
module apw_ctrl
    import apw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_restart,
    input  logic        i_step,
    output logic [11:0] o_row,
    output logic [8:0]  o_col,
    output logic [5:0]  o_ch,
    output t_win        o_win
);
    logic [11:0] r_row, n_row;
    logic [8:0]  r_col, n_col;
    logic [5:0]  r_ch, n_ch;
    logic [10:0] pitch;
    logic [12:0] frame_rows;
    logic [11:0] dr;
    logic [8:0]  dc;
    logic [10:0] dr_div3;
    logic [7:0]  dc_div3;
    logic [9:0]  oi;
    logic [6:0]  oj;
    logic        dr_ok, dc_ok, row_ok, col_ok;

    assign pitch = 11'(i_cfg.out_w * i_cfg.stride);
    assign frame_rows = (i_cfg.win_h > i_cfg.stride)
        ? 13'(13'(i_cfg.out_h - 11'd1) * i_cfg.stride + i_cfg.win_h)
        : 13'(i_cfg.out_h * i_cfg.stride);

    assign row_ok = ({1'b0, r_row} + 13'd1) >= {10'd0, i_cfg.win_h};
    assign col_ok = ({1'b0, r_col} + 10'd1) >= {7'd0, i_cfg.win_w};
    assign dr = 12'(r_row + 12'd1 - {9'd0, i_cfg.win_h});
    assign dc = 9'(r_col + 9'd1 - {6'd0, i_cfg.win_w});

    // divide by three as a multiply by 2731 / 8192, exact below 8192
    assign dr_div3 = 11'((24'(dr) * 24'd2731) >> 13);
    assign dc_div3 = 8'((21'(dc) * 21'd2731) >> 13);

    // stride is 1..4: quotient and remainder by small constants
    always_comb begin
        case (i_cfg.stride)
            3'd2: begin
                dr_ok = ~dr[0]; dc_ok = ~dc[0];
                oi = 10'(dr >> 1); oj = 7'(dc >> 1);
            end
            3'd3: begin
                dr_ok = ({1'b0, dr_div3} * 12'd3) == dr;
                dc_ok = ({1'b0, dc_div3} * 9'd3) == dc;
                oi = 10'(dr_div3); oj = 7'(dc_div3);
            end
            3'd4: begin
                dr_ok = dr[1:0] == '0; dc_ok = dc[1:0] == '0;
                oi = 10'(dr >> 2); oj = 7'(dc >> 2);
            end
            default: begin
                dr_ok = 1'b1; dc_ok = 1'b1;
                oi = 10'(dr); oj = 7'(dc);
            end
        endcase
    end

    always_comb begin
        o_win.dr = dr;
        o_win.dc = dc;
        o_win.oi = oi;
        o_win.oj = oj;
        o_win.ch = r_ch;
        o_win.hit = row_ok && col_ok && dr_ok && dc_ok
                    && ({2'd0, dr} < 14'(i_cfg.out_h * i_cfg.stride))
                    && ({2'd0, dc} < 11'(i_cfg.out_w * i_cfg.stride))
                    && ({2'd0, r_col} < pitch);
        o_win.last = ({1'b0, oi} == 11'(i_cfg.out_h - 11'd1))
                     && ({1'b0, oj} == 8'(i_cfg.out_w - 8'd1))
                     && ({1'b0, r_ch} == 7'(i_cfg.channels - 7'd1));
    end

    always_comb begin
        n_row = r_row; n_col = r_col; n_ch = r_ch;
        if (i_restart) begin
            n_row = '0; n_col = '0; n_ch = '0;
        end else if (i_step) begin
            if ({1'b0, r_ch} + 7'd1 >= i_cfg.channels) begin
                n_ch = '0;
                if ({2'd0, r_col} + 11'd1 >= pitch) begin
                    n_col = '0;
                    n_row = ({1'b0, r_row} + 13'd1 >= frame_rows) ? '0 : r_row + 12'd1;
                end else begin
                    n_col = r_col + 9'd1;
                end
            end else begin
                n_ch = r_ch + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0; r_col <= '0; r_ch <= '0;
        end else begin
            r_row <= n_row; r_col <= n_col; r_ch <= n_ch;
        end
    end

    assign o_row = r_row;
    assign o_col = r_col;
    assign o_ch  = r_ch;
endmodule

// ----- test/apw_checker.sv -----
// transaction monitor, pooling predictor and result scoreboard for average_pooling_window
`timescale 1ns / 1ps
module apw_checker
    import apw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [7:0]            pixel,
    input  logic                  res_valid,
    input  logic                  res_stall,
    input  logic [7:0]            average,
    input  logic [9:0]            out_row,
    input  logic [6:0]            out_col,
    input  logic [5:0]            out_channel,
    input  logic                  frame_last,
    output int                    errors,
    output int                    pending,
    output int                    results
);

    typedef struct packed {
        logic [7:0] avg;
        logic [9:0] row;
        logic [6:0] col;
        logic [5:0] ch;
        logic       last;
    } t_pool_result;

    t_pool_result pool_q[$];
    t_cfg         cfg;
    int unsigned  row_cnt, col_cnt, ch_cnt;
    logic [7:0]   line_mem [0:32767];

    initial begin
        errors  = 0;
        pending = 0;
        results = 0;
    end

    function automatic int unsigned sat(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned mem_addr(int unsigned r, int unsigned c, int unsigned k);
        return ((r % 4) * 8192 + c * cfg.channels + k) % 32768;
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // store the byte, emit a window mean when it is a window corner, then advance
    task automatic pool_byte(input logic [7:0] px);
        int unsigned  pitch, dr, dc, sum, rows;
        t_pool_result e;
        pitch = cfg.out_w * cfg.stride;
        line_mem[mem_addr(row_cnt, col_cnt, ch_cnt)] = px;
        if (row_cnt + 1 >= cfg.win_h && col_cnt + 1 >= cfg.win_w) begin
            dr = row_cnt + 1 - cfg.win_h;
            dc = col_cnt + 1 - cfg.win_w;
            if (dr % cfg.stride == 0 && dc % cfg.stride == 0 &&
                dr / cfg.stride < cfg.out_h && dc / cfg.stride < cfg.out_w &&
                col_cnt < pitch) begin
                sum = 0;
                for (int t = 0; t < cfg.win_h; t++)
                    for (int z = 0; z < cfg.win_w; z++)
                        sum += line_mem[mem_addr(dr + t, dc + z, ch_cnt)];
                e.avg  = 8'(sum / (cfg.win_w * cfg.win_h));
                e.row  = 10'(dr / cfg.stride);
                e.col  = 7'(dc / cfg.stride);
                e.ch   = 6'(ch_cnt);
                e.last = (e.row == cfg.out_h - 1 && e.col == cfg.out_w - 1 &&
                          ch_cnt == cfg.channels - 1);
                pool_q.push_back(e);
            end
        end
        rows = (cfg.win_h > cfg.stride) ? (cfg.out_h - 1) * cfg.stride + cfg.win_h
                                        : cfg.out_h * cfg.stride;
        if (++ch_cnt >= cfg.channels) begin
            ch_cnt = 0;
            if (++col_cnt >= pitch) begin
                col_cnt = 0;
                if (++row_cnt >= rows) row_cnt = 0;
            end
        end
    endtask

    always @(posedge clk) begin
        t_pool_result e;
        logic         restart;
        if (!rst_n) begin
            cfg     = '{channels: 7'd1, out_w: 8'd1, out_h: 11'd1,
                        win_w: 3'd1, win_h: 3'd1, stride: 3'd1};
            row_cnt = 0;
            col_cnt = 0;
            ch_cnt  = 0;
            pool_q.delete();
        end else begin
            if (cfg_we) begin
                restart = 1'b1;
                case (cfg_index)
                    REG_CHANNELS: cfg.channels = 7'(sat(cfg_data, 1, 64));
                    REG_OUT_W:    cfg.out_w    = 8'(sat(cfg_data, 1, 128));
                    REG_OUT_H:    cfg.out_h    = 11'(sat(cfg_data, 1, 1024));
                    REG_WIN_W:    cfg.win_w    = 3'(sat(cfg_data, 1, 4));
                    REG_WIN_H:    cfg.win_h    = 3'(sat(cfg_data, 1, 4));
                    REG_STRIDE:   cfg.stride   = 3'(sat(cfg_data, 1, 4));
                    default:      restart = 1'b0;
                endcase
                if (restart) begin
                    row_cnt = 0;
                    col_cnt = 0;
                    ch_cnt  = 0;
                end
            end
            if (res_valid && !res_stall) begin
                results++;
                if (pool_q.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none actual avg %0d row %0d col %0d",
                             $time, average, out_row, out_col);
                end else begin
                    e = pool_q.pop_front();
                    check_field("average", e.avg, average);
                    check_field("out_row", e.row, out_row);
                    check_field("out_col", e.col, out_col);
                    check_field("out_channel", e.ch, out_channel);
                    check_field("frame_last", e.last, frame_last);
                end
            end
            if (in_valid && !in_stall) pool_byte(pixel);
        end
        pending = pool_q.size();
    end

endmodule

// ----- test/testbench.sv -----
// stimulus and verdict for the average_pooling_window testbench
`timescale 1ns / 1ps
module testbench
    import apw_pkg::*;
;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_pixel;
    logic                  o_valid;
    logic                  i_stall;
    logic [7:0]            o_average;
    logic [9:0]            o_out_row;
    logic [6:0]            o_out_col;
    logic [5:0]            o_out_channel;
    logic                  o_frame_last;

    int errors, pending, results;
    int pixels_sent;
    int phase_cnt;
    bit calm;        // no idling on either side while set
    bit hold_req;    // asks the receiver for one long hold-off
    int hold_left;

    average_pooling_window dut (.*);

    apw_checker u_checker (
        .clk        (i_clk),
        .rst_n      (i_rst_n),
        .cfg_we     (i_cfg_we),
        .cfg_index  (i_cfg_index),
        .cfg_data   (i_cfg_data),
        .in_valid   (i_valid),
        .in_stall   (o_stall),
        .pixel      (i_pixel),
        .res_valid  (o_valid),
        .res_stall  (i_stall),
        .average    (o_average),
        .out_row    (o_out_row),
        .out_col    (o_out_col),
        .out_channel(o_out_channel),
        .frame_last (o_frame_last),
        .errors     (errors),
        .pending    (pending),
        .results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // safety net in case the block hangs
    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", pending);
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls, a calm stretch and one long hold-off on request
    initial begin
        i_stall   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (calm) begin
                i_stall = 1'b0;
            end else begin
                i_stall = ($urandom_range(99) < 38);
            end
        end
    end

    function automatic int limit(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // one input transaction: random idle cycles, then hold the byte until accepted
    task automatic send_pixel(input logic [7:0] px);
        bit stalled;
        if (!calm)
            while ($urandom_range(99) < 38) begin
                i_valid = 1'b0;
                @(negedge i_clk);
            end
        i_valid = 1'b1;
        i_pixel = px;
        // stall only depends on registers, so its value here holds at the next edge
        do begin
            stalled = o_stall;
            @(negedge i_clk);
        end while (stalled);
        pixels_sent++;
    endtask

    // drain all results, allow the last no-result item to retire, then reprogram
    task automatic program_regs(input int raw [6]);
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_we = 1'b1;
        for (int k = 0; k < 6; k++) begin
            i_cfg_index = CFG_IDX_W'(k);
            i_cfg_data  = CFG_DATA_W'(raw[k]);
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
        phase_cnt++;
    endtask

    // items in one full frame for the programmed (saturated) settings
    function automatic int frame_items(input int raw [6]);
        int ch, ow, oh, wh, st, rows;
        ch   = limit(raw[REG_CHANNELS], 1, 64);
        ow   = limit(raw[REG_OUT_W], 1, 128);
        oh   = limit(raw[REG_OUT_H], 1, 1024);
        wh   = limit(raw[REG_WIN_H], 1, 4);
        st   = limit(raw[REG_STRIDE], 1, 4);
        rows = (wh > st) ? (oh - 1) * st + wh : oh * st;
        return rows * ow * st * ch;
    endfunction

    // pattern: 0 random with frequent extremes, 1 first half all ones then zeros
    task automatic run_phase(input int raw [6], input int n, input int pattern);
        logic [7:0] px;
        program_regs(raw);
        for (int k = 0; k < n; k++) begin
            if (pattern == 1)
                px = (k < n / 2) ? 8'hFF : 8'h00;
            else case ($urandom_range(7))
                0:       px = 8'h00;
                1:       px = 8'hFF;
                default: px = $urandom_range(255);
            endcase
            send_pixel(px);
        end
        i_valid = 1'b0;
    endtask

    initial begin
        int raw [6];
        int rand_items, n, len, st, ch;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_pixel     = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        pixels_sent = 0;
        phase_cnt   = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // 2x2 windows at stride 2, full-scale then zero bytes
        raw = '{1, 2, 2, 2, 2, 2};
        run_phase(raw, frame_items(raw), 1);
        // window taller than stride, under-range writes saturate to one
        raw = '{0, 3, 2, 0, 4, 1};
        run_phase(raw, frame_items(raw), 0);
        // largest window and stride, over-range writes saturate to four
        raw = '{2, 2, 1, 7, 7, 7};
        run_phase(raw, frame_items(raw), 1);
        // most channels, frame end on the last channel; output held off meanwhile
        raw = '{100, 1, 1, 1, 1, 1};
        hold_req = 1'b1;
        run_phase(raw, frame_items(raw), 0);
        // widest output row, no idling on either side
        raw = '{1, 200, 1, 1, 1, 1};
        calm = 1'b1;
        run_phase(raw, frame_items(raw), 0);
        calm = 1'b0;
        // tallest frame setting, first rows only
        raw = '{1, 1, 2047, 1, 1, 1};
        run_phase(raw, 64, 0);

        // random settings, frames with random content
        rand_items = 0;
        while (rand_items < 250) begin
            st  = $urandom_range(1, 4);
            ch  = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 3);
            raw[REG_STRIDE]   = st;
            raw[REG_WIN_W]    = $urandom_range(1, st);
            raw[REG_WIN_H]    = $urandom_range(1, 4);
            raw[REG_CHANNELS] = ch;
            raw[REG_OUT_W]    = $urandom_range(1, limit(8192 / (st * ch), 1, 8));
            raw[REG_OUT_H]    = $urandom_range(1, 4);
            len = frame_items(raw);
            n   = (len <= 200) ? len * $urandom_range(1, 2) : $urandom_range(50, 200);
            run_phase(raw, n, 0);
            rand_items += n;
        end

        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        $display("covered %0d configuration phases, %0d pixels in, %0d window results out",
                 phase_cnt, pixels_sent, results);
        $display("including saturated registers, 4x4 windows, 64 channels and a 1024-row setting");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/apw_pkg.sv
rtl/apw_ram.sv
rtl/apw_cfg.sv
rtl/apw_ctrl.sv
rtl/average_pooling_window.sv
test/apw_checker.sv
test/testbench.sv
